// ===== hw/rtl/tpq_pkg.sv =====
// Package: shared widths and a payload type for the triangle point query block.
`default_nettype none
package tpq_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 8;
	localparam int OUT_BITS    = 16;
	localparam int HEIGHT_W    = 32;
	// numerator/denominator magnitudes
	localparam int NUM_W = 64;
	localparam int DEN_W = 2 * COORD_WIDTH + 2;

	typedef struct packed {
		logic             inside_res;
		logic             vertical_plane;
		logic [NUM_W-1:0] un;
		logic [DEN_W-1:0] ud;
		logic             negq;
	} div_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tpq_if.sv =====
// Interface: valid/ready channel carrying one item payload.
`default_nettype none
interface tpq_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/triangle_point_query_top.sv =====
// Top level: point-in-triangle test and plane height, fully pipelined.
// Pipeline: 4 front stages, 16 divider stages and 1 output stage.
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or taken, and a stall freezes every stage.
// Reset (arst_n, asynchronous) clears only the stage valid bits.
`default_nettype none
module triangle_point_query_top #(
	parameter int FRAC_BITS = tpq_pkg::FRAC_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	tpq_if.sink      in_ch,
	tpq_if.source    out_ch
);
	logic en, f_valid;
	tpq_pkg::div_req_t f_req;
	logic d_valid, d_in, d_vert;
	logic [tpq_pkg::HEIGHT_W-1:0] d_h;

	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	tpq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .en,
		.in_valid(in_ch.valid),
		.x0(in_ch.data.vert0_x), .y0(in_ch.data.vert0_y), .z0(in_ch.data.vert0_z),
		.x1(in_ch.data.vert1_x), .y1(in_ch.data.vert1_y), .z1(in_ch.data.vert1_z),
		.x2(in_ch.data.vert2_x), .y2(in_ch.data.vert2_y), .z2(in_ch.data.vert2_z),
		.qx(in_ch.data.query_x), .qz(in_ch.data.query_z),
		.out_valid(f_valid), .out_req(f_req)
	);

	tpq_div u_div (
		.clk, .arst_n, .en,
		.in_valid(f_valid), .in_req(f_req),
		.out_valid(d_valid), .inside_res(d_in), .vertical_plane(d_vert),
		.plane_height(d_h)
	);

	assign out_ch.valid               = d_valid;
	assign out_ch.data.inside_res     = d_in;
	assign out_ch.data.vertical_plane = d_vert;
	assign out_ch.data.plane_height   = d_h;

	// vertical plane always reports zero height
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.vertical_plane |-> out_ch.data.plane_height == '0)
		else $error("vertical plane with nonzero height");
	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("stalled result changed");
	// no intake while the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !in_ch.ready)
		else $error("intake during stall");
endmodule
`default_nettype wire

// ===== hw/rtl/tpq_front.sv =====
// Front end: edge functions, normal, and height numerator over pipelined stages.
`default_nettype none
module tpq_front #(
	parameter int FRAC_BITS = tpq_pkg::FRAC_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   in_valid,
	input  wire logic signed [tpq_pkg::COORD_WIDTH-1:0] x0, y0, z0, x1, y1, z1,
	input  wire logic signed [tpq_pkg::COORD_WIDTH-1:0] x2, y2, z2, qx, qz,
	output logic                                        out_valid,
	output tpq_pkg::div_req_t                           out_req
);
	localparam int DW = tpq_pkg::COORD_WIDTH + 1;       // differences
	localparam int PW = 2 * DW + 1;            // products and their sums
	localparam int SH = tpq_pkg::OUT_BITS - FRAC_BITS;
	localparam int NW = tpq_pkg::NUM_W;

	// stage 1: differences
	logic               v_s1;
	logic signed [DW-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1, qdx_s1, qdz_s1;
	logic signed [DW-1:0] e0a_s1, e0b_s1, e0c_s1, e0d_s1;
	logic signed [DW-1:0] e1a_s1, e1b_s1, e1c_s1, e1d_s1;
	logic signed [DW-1:0] e2a_s1, e2b_s1, e2c_s1, e2d_s1;
	logic signed [tpq_pkg::COORD_WIDTH-1:0] y0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= DW'(x1) - DW'(x0);
			ay_s1  <= DW'(y1) - DW'(y0);
			az_s1  <= DW'(z1) - DW'(z0);
			bx_s1  <= DW'(x2) - DW'(x0);
			by_s1  <= DW'(y2) - DW'(y0);
			bz_s1  <= DW'(z2) - DW'(z0);
			qdx_s1 <= DW'(qx) - DW'(x0);
			qdz_s1 <= DW'(qz) - DW'(z0);
			e0a_s1 <= DW'(qx) - DW'(x1); e0b_s1 <= DW'(z0) - DW'(z1);
			e0c_s1 <= DW'(x0) - DW'(x1); e0d_s1 <= DW'(qz) - DW'(z1);
			e1a_s1 <= DW'(qx) - DW'(x2); e1b_s1 <= DW'(z1) - DW'(z2);
			e1c_s1 <= DW'(x1) - DW'(x2); e1d_s1 <= DW'(qz) - DW'(z2);
			e2a_s1 <= DW'(qx) - DW'(x0); e2b_s1 <= DW'(z2) - DW'(z0);
			e2c_s1 <= DW'(x2) - DW'(x0); e2d_s1 <= DW'(qz) - DW'(z0);
			y0_s1  <= y0;
		end
	end

	// stage 2: edge values and normal components
	logic               v_s2;
	logic signed [PW-1:0] d0_s2, d1_s2, d2_s2, nx_s2, ny_s2, nz_s2;
	logic signed [DW-1:0] qdx_s2, qdz_s2;
	logic signed [tpq_pkg::COORD_WIDTH-1:0] y0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d0_s2 <= PW'(e0a_s1 * e0b_s1) - PW'(e0c_s1 * e0d_s1);
			d1_s2 <= PW'(e1a_s1 * e1b_s1) - PW'(e1c_s1 * e1d_s1);
			d2_s2 <= PW'(e2a_s1 * e2b_s1) - PW'(e2c_s1 * e2d_s1);
			nx_s2 <= PW'(ay_s1 * bz_s1) - PW'(az_s1 * by_s1);
			ny_s2 <= PW'(az_s1 * bx_s1) - PW'(ax_s1 * bz_s1);
			nz_s2 <= PW'(ax_s1 * by_s1) - PW'(ay_s1 * bx_s1);
			qdx_s2 <= qdx_s1;
			qdz_s2 <= qdz_s1;
			y0_s2  <= y0_s1;
		end
	end

	// stage 3: inside test, numerator products
	logic               v_s3, in_s3, vert_s3;
	logic signed [NW-1:0] p1_s3, p2_s3, p3_s3;
	logic signed [PW-1:0] den_s3;
	logic neg_c, pos_c;

	assign neg_c = d0_s2[PW-1] | d1_s2[PW-1] | d2_s2[PW-1];
	assign pos_c = (!d0_s2[PW-1] && d0_s2 != '0) || (!d1_s2[PW-1] && d1_s2 != '0)
		|| (!d2_s2[PW-1] && d2_s2 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s3   <= !(neg_c && pos_c);
			vert_s3 <= (ny_s2 == '0);
			p1_s3   <= NW'(nx_s2 * qdx_s2);
			p2_s3   <= NW'(nz_s2 * qdz_s2);
			p3_s3   <= -NW'(y0_s2 * ny_s2);
			den_s3  <= -ny_s2;
		end
	end

	// stage 4: scaled numerator, magnitudes, quotient sign
	logic signed [NW-1:0] num_c;
	assign num_c = (p1_s3 + p2_s3 + p3_s3) <<< SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_req.inside_res     <= in_s3;
			out_req.vertical_plane <= vert_s3;
			out_req.un   <= num_c[NW-1] ? NW'(-num_c) : NW'(num_c);
			out_req.ud   <= den_s3[PW-1] ? tpq_pkg::DEN_W'(-den_s3)
				: tpq_pkg::DEN_W'(den_s3);
			out_req.negq <= (num_c[NW-1] != den_s3[PW-1]) && num_c != '0;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/tpq_div.sv =====
// Pipelined restoring divider, several quotient bits a stage, then saturation.
`default_nettype none
module tpq_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  tpq_pkg::div_req_t  in_req,
	output logic               out_valid,
	output logic               inside_res,
	output logic               vertical_plane,
	output logic [tpq_pkg::HEIGHT_W-1:0] plane_height
);
	localparam int NW  = tpq_pkg::NUM_W;
	localparam int DWD = tpq_pkg::DEN_W;
	localparam int BPS = 4;               // quotient bits per stage
	localparam int NST = NW / BPS;
	localparam int RW  = DWD + 1;

	logic           v_s    [NST+1];
	logic [RW-1:0]  r_s    [NST+1];
	logic [NW-1:0]  q_s    [NST+1];   // holds remaining dividend bits, then quotient
	logic [DWD-1:0] d_s    [NST+1];
	logic           ins_s  [NST+1];
	logic           vert_s [NST+1];
	logic           neg_s  [NST+1];

	assign v_s[0]    = in_valid;
	assign r_s[0]    = '0;
	assign q_s[0]    = in_req.un;
	assign d_s[0]    = in_req.ud;
	assign ins_s[0]  = in_req.inside_res;
	assign vert_s[0] = in_req.vertical_plane;
	assign neg_s[0]  = in_req.negq;

	for (genvar g = 0; g < NST; g++) begin : g_st
		logic [RW-1:0] r_c;
		logic [NW-1:0] q_c;
		always_comb begin
			r_c = r_s[g];
			q_c = q_s[g];
			for (int b = 0; b < BPS; b++) begin
				r_c = {r_c[RW-2:0], q_c[NW-1]};
				q_c = {q_c[NW-2:0], 1'b0};
				if (r_c >= {1'b0, d_s[g]}) begin
					r_c = r_c - {1'b0, d_s[g]};
					q_c[0] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[g+1]    <= r_c;
				q_s[g+1]    <= q_c;
				d_s[g+1]    <= d_s[g];
				ins_s[g+1]  <= ins_s[g];
				vert_s[g+1] <= vert_s[g];
				neg_s[g+1]  <= neg_s[g];
			end
		end
	end

	// saturation to 32 bits
	logic [NW-1:0] uq;
	logic [tpq_pkg::HEIGHT_W-1:0] h_c;
	assign uq = q_s[NST];
	always_comb begin
		if (vert_s[NST]) begin
			h_c = '0;
		end else if (neg_s[NST]) begin
			h_c = (uq > NW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-uq);
		end else begin
			h_c = (uq > NW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : uq[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_res     <= ins_s[NST];
			vertical_plane <= vert_s[NST];
			plane_height   <= h_c;
		end
	end
endmodule
`default_nettype wire
